// ----- hw/rtl/mtfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfp_pkg
// Types and constants shared by the telemetry frame parser and its decoder.
// ----------------------------------------------------------------------------
package mtfp_pkg;

    // Frame framing bytes
    localparam logic [7:0] SYNC_DOLLAR   = 8'h24;  // '$'
    localparam logic [7:0] SYNC_M        = 8'h4D;  // 'M'
    localparam logic [7:0] DIR_TO_DEV    = 8'h3C;  // '<'
    localparam logic [7:0] DIR_FROM_DEV  = 8'h3E;  // '>'

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_CODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT_CODE = 1'd1;
    localparam logic [7:0] LINK_CODE_RST = 8'h2D;
    localparam logic [7:0] BATT_CODE_RST = 8'h2E;

    // Payload size limits
    localparam logic [7:0] LEGACY_MIN_LEN  = 8'd10;
    localparam logic [7:0] COMPACT_MIN_LEN = 8'd4;
    localparam logic [7:0] BATT_MIN_LEN    = 8'd6;

    // Number of leading payload bytes the decoder looks at
    localparam int unsigned DEC_BYTES = 6;

    // Result kinds
    localparam logic KIND_LINK = 1'b0;
    localparam logic KIND_BATT = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_M    = 3'd1,
        PH_DIR  = 3'd2,
        PH_LEN  = 3'd3,
        PH_FUNC = 3'd4,
        PH_PAY  = 3'd5,
        PH_SUM  = 3'd6
    } t_phase;

    typedef logic [DEC_BYTES-1:0][7:0] t_head;

    // Frame summary handed to the decoder
    typedef struct packed {
        logic       toward_host;
        logic [7:0] func;
        logic [7:0] count;
        logic [7:0] link_code;
        logic [7:0] batt_code;
    } t_frame_info;

    // Decoded result
    typedef struct packed {
        logic        hit;
        logic        kind;
        logic [7:0]  rssi_first;
        logic [7:0]  rssi_second;
        logic [7:0]  link_qual;
        logic [7:0]  signal_to_noise;
        logic [7:0]  transmit_power;
        logic [15:0] batt_voltage;
        logic [15:0] batt_current;
        logic [15:0] used_capacity;
    } t_result;

endpackage

// ----- hw/rtl/mtfp_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfp_decode
// Turns a checked frame's code, length and head bytes into a link statistics
// or battery result; flags frames that give no result.
// ----------------------------------------------------------------------------
module mtfp_decode (
    input  mtfp_pkg::t_frame_info i_info,
    input  mtfp_pkg::t_head       i_head,
    output mtfp_pkg::t_result     o_result
);
    import mtfp_pkg::*;

    logic w_is_link;
    logic w_is_batt;

    // Link statistics take priority when both codes match
    assign w_is_link = (i_info.func == i_info.link_code);
    assign w_is_batt = !w_is_link && (i_info.func == i_info.batt_code);

    always_comb begin
        o_result = '0;
        if (i_info.toward_host) begin
            if (w_is_link) begin
                if (i_info.count >= LEGACY_MIN_LEN) begin
                    // legacy layout: two separate RSSI bytes
                    o_result.hit             = 1'b1;
                    o_result.kind            = KIND_LINK;
                    o_result.rssi_first      = i_head[0];
                    o_result.rssi_second     = i_head[1];
                    o_result.link_qual       = i_head[2];
                    o_result.signal_to_noise = i_head[3];
                    o_result.transmit_power  = i_head[4];
                end else if (i_info.count >= COMPACT_MIN_LEN) begin
                    // compact layout: one RSSI byte used for both
                    o_result.hit             = 1'b1;
                    o_result.kind            = KIND_LINK;
                    o_result.rssi_first      = i_head[0];
                    o_result.rssi_second     = i_head[0];
                    o_result.link_qual       = i_head[1];
                    o_result.signal_to_noise = i_head[2];
                    o_result.transmit_power  = i_head[3];
                end
            end else if (w_is_batt && (i_info.count >= BATT_MIN_LEN)) begin
                // big-endian 16-bit triplet
                o_result.hit           = 1'b1;
                o_result.kind          = KIND_BATT;
                o_result.batt_voltage  = {i_head[0], i_head[1]};
                o_result.batt_current  = {i_head[2], i_head[3]};
                o_result.used_capacity = {i_head[4], i_head[5]};
            end
        end
    end

endmodule

// ----- hw/rtl/msp_telemetry_frame_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_telemetry_frame_parser_unit
// Byte-wide parser for '$' 'M' <dir> <len> <func> <payload> <xor> frames;
// emits link statistics or battery telemetry from frames sent by the device.
// ----------------------------------------------------------------------------
//  Channel   Handshake                   Payload
//  in        i_in_valid / o_in_stall     i_rx_byte
//  out       o_out_valid / i_out_stall   o_frame_kind .. o_used_capacity
//  cfg       i_cfg_we                    i_cfg_index, i_cfg_data
//
//  One byte per cycle. The result of a checksum byte is registered and
//  appears in the cycle after that byte is taken. The input is stalled only
//  while a result is held and the output is stalled. Reset is synchronous;
//  it returns the parser to hunting for '$' and restores the function codes.
// ----------------------------------------------------------------------------
module msp_telemetry_frame_parser_unit #(
    parameter int unsigned HEAD_BYTES = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // byte input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_rx_byte,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_frame_kind,
    output logic signed [7:0]                 o_rssi_first,
    output logic signed [7:0]                 o_rssi_second,
    output logic [7:0]                        o_link_qual,
    output logic signed [7:0]                 o_signal_to_noise,
    output logic [7:0]                        o_transmit_power,
    output logic [15:0]                       o_batt_voltage,
    output logic [15:0]                       o_batt_current,
    output logic [15:0]                       o_used_capacity,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [mtfp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]                        i_cfg_data
);
    import mtfp_pkg::*;

    localparam int unsigned IDX_W = $clog2(HEAD_BYTES);

    // Configuration registers
    logic [7:0] r_link_code;
    logic [7:0] r_batt_code;

    // Parser state
    t_phase     r_phase, n_phase;
    logic       r_toward_host, n_toward_host;
    logic [7:0] r_length, n_length;
    logic [7:0] r_func, n_func;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_count, n_count;
    logic [7:0] r_head [HEAD_BYTES];

    // Result register
    logic    r_out_valid;
    t_result r_out;

    logic        w_accept;
    logic        w_head_we;
    logic        w_sum_ok;
    logic        w_load;
    t_frame_info w_info;
    t_head       w_head;
    t_result     w_result;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_code <= LINK_CODE_RST;
            r_batt_code <= BATT_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINK_CODE: r_link_code <= i_cfg_data;
                CFG_BATT_CODE: r_batt_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Parser next state
    always_comb begin
        n_phase       = r_phase;
        n_toward_host = r_toward_host;
        n_length      = r_length;
        n_func        = r_func;
        n_xor         = r_xor;
        n_count       = r_count;
        w_head_we     = 1'b0;
        unique case (r_phase)
            PH_M: begin
                if (i_rx_byte == SYNC_M) begin
                    n_phase = PH_DIR;
                end else begin
                    n_phase       = PH_IDLE;
                    n_toward_host = 1'b0;
                    n_length      = '0;
                    n_func        = '0;
                    n_xor         = '0;
                    n_count       = '0;
                end
            end
            PH_DIR: begin
                if (i_rx_byte == DIR_FROM_DEV || i_rx_byte == DIR_TO_DEV) begin
                    n_toward_host = (i_rx_byte == DIR_FROM_DEV);
                    n_phase       = PH_LEN;
                end else begin
                    n_phase       = PH_IDLE;
                    n_toward_host = 1'b0;
                    n_length      = '0;
                    n_func        = '0;
                    n_xor         = '0;
                    n_count       = '0;
                end
            end
            PH_LEN: begin
                n_length = i_rx_byte;
                n_xor    = i_rx_byte;
                n_count  = '0;
                n_phase  = PH_FUNC;
            end
            PH_FUNC: begin
                n_func  = i_rx_byte;
                n_xor   = r_xor ^ i_rx_byte;
                n_phase = (r_length == 8'd0) ? PH_SUM : PH_PAY;
            end
            PH_PAY: begin
                w_head_we = (r_count < 8'(HEAD_BYTES));
                n_xor     = r_xor ^ i_rx_byte;
                n_count   = r_count + 8'd1;
                if (n_count >= r_length) begin
                    n_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                n_phase       = PH_IDLE;
                n_toward_host = 1'b0;
                n_length      = '0;
                n_func        = '0;
                n_xor         = '0;
                n_count       = '0;
            end
            default: begin
                n_phase = (i_rx_byte == SYNC_DOLLAR) ? PH_M : PH_IDLE;
            end
        endcase
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_toward_host <= 1'b0;
            r_length      <= '0;
            r_func        <= '0;
            r_xor         <= '0;
            r_count       <= '0;
        end else if (w_accept) begin
            r_phase       <= n_phase;
            r_toward_host <= n_toward_host;
            r_length      <= n_length;
            r_func        <= n_func;
            r_xor         <= n_xor;
            r_count       <= n_count;
        end
    end

    // Payload head store, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept && w_head_we) begin
            r_head[r_count[IDX_W-1:0]] <= i_rx_byte;
        end
    end

    // Decoder taps on the leading head bytes
    always_comb begin
        for (int k = 0; k < DEC_BYTES; k++) begin
            w_head[k] = r_head[k];
        end
    end

    assign w_info.toward_host = r_toward_host;
    assign w_info.func        = r_func;
    assign w_info.count       = r_count;
    assign w_info.link_code   = r_link_code;
    assign w_info.batt_code   = r_batt_code;

    mtfp_decode u_decode (
        .i_info   (w_info),
        .i_head   (w_head),
        .o_result (w_result)
    );

    // Checksum byte matches and decode gives a result
    assign w_sum_ok = (r_phase == PH_SUM) && (r_xor == i_rx_byte);
    assign w_load   = w_accept && w_sum_ok && w_result.hit;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frame_kind      = r_out.kind;
    assign o_rssi_first      = r_out.rssi_first;
    assign o_rssi_second     = r_out.rssi_second;
    assign o_link_qual       = r_out.link_qual;
    assign o_signal_to_noise = r_out.signal_to_noise;
    assign o_transmit_power  = r_out.transmit_power;
    assign o_batt_voltage    = r_out.batt_voltage;
    assign o_batt_current    = r_out.batt_current;
    assign o_used_capacity   = r_out.used_capacity;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the telemetry frame parser. Bytes are fed through
// the valid/stall input channel and every decoded result is compared, field
// by field, with an in-bench parser model or a given record. A short table
// of directed frames runs first; random frames, broken headers and noise
// follow under several function-code settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
    import mtfp_pkg::*;

    localparam int HEAD            = 6;     // payload bytes the parser keeps
    localparam int RANDOM_BYTES    = 1250;
    localparam int RANDOM_SETTINGS = 7;
    localparam int SETTLE_CYCLES   = 4;     // result is registered after its checksum byte
    // Longest quiet stretch in a good run is one long gap or stall plus the
    // settle wait; this is many times that.
    localparam int WATCHDOG_LIMIT  = 2000;

    // One decoded telemetry record
    typedef struct packed {
        logic              kind;
        logic signed [7:0] rssi_first;
        logic signed [7:0] rssi_second;
        logic [7:0]        link_qual;
        logic signed [7:0] signal_to_noise;
        logic [7:0]        transmit_power;
        logic [15:0]       batt_voltage;
        logic [15:0]       batt_current;
        logic [15:0]       used_capacity;
    } t_telem;

    // Where a directed frame takes its expectation from
    typedef enum logic [1:0] {
        FROM_MODEL = 2'd0,
        NO_RESULT  = 2'd1,
        GIVEN      = 2'd2
    } t_expect_src;

    // One row of the directed table: a frame, or a change of function codes
    typedef struct packed {
        logic             is_cfg;
        logic [7:0]       link_c;
        logic [7:0]       batt_c;
        logic [7:0]       second;
        logic [7:0]       dir;
        logic [7:0]       len;
        logic [7:0]       func;
        logic [0:11][7:0] pay;
        logic             bad_sum;
        t_expect_src      src;
        t_telem           given;
    } t_row;

    // DUT connections, all inputs known from time zero
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [7:0]        i_rx_byte   = 8'h00;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_frame_kind;
    logic signed [7:0] o_rssi_first;
    logic signed [7:0] o_rssi_second;
    logic [7:0]        o_link_qual;
    logic signed [7:0] o_signal_to_noise;
    logic [7:0]        o_transmit_power;
    logic [15:0]       o_batt_voltage;
    logic [15:0]       o_batt_current;
    logic [15:0]       o_used_capacity;
    logic              i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_LINK_CODE;
    logic [7:0]        i_cfg_data  = 8'h00;

    // Parser model state
    t_phase     pr_phase   = PH_IDLE;
    logic       pr_to_host = 1'b0;
    logic [7:0] pr_len     = 8'h00;
    logic [7:0] pr_func    = 8'h00;
    logic [7:0] pr_xor     = 8'h00;
    logic [7:0] pr_count   = 8'h00;
    logic [7:0] pr_head [HEAD];
    logic [7:0] link_code  = LINK_CODE_RST;
    logic [7:0] batt_code  = BATT_CODE_RST;

    t_telem telemetry_q [$];
    t_row   plan [$];

    bit hold_prediction = 1'b0;
    int err_count   = 0;
    int bytes_sent  = 0;
    int link_seen   = 0;
    int batt_seen   = 0;
    int code_sets   = 0;
    int quiet       = 0;
    int send_calm   = 0;
    int stall_left  = 0;
    int free_left   = 0;

    msp_telemetry_frame_parser_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_frame_kind      (o_frame_kind),
        .o_rssi_first      (o_rssi_first),
        .o_rssi_second     (o_rssi_second),
        .o_link_qual       (o_link_qual),
        .o_signal_to_noise (o_signal_to_noise),
        .o_transmit_power  (o_transmit_power),
        .o_batt_voltage    (o_batt_voltage),
        .o_batt_current    (o_batt_current),
        .o_used_capacity   (o_used_capacity),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Append to the directed table and to the expected results
    function automatic void plan_add(t_row r);
        plan.insert(plan.size(), r);
    endfunction

    function automatic void expect_add(t_telem t);
        telemetry_q.insert(telemetry_q.size(), t);
    endfunction

    // Idle length: mostly none, often short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_telem telem_link(logic [7:0] r1, logic [7:0] r2, logic [7:0] lq,
                                          logic [7:0] snr, logic [7:0] txp);
        t_telem t;
        t = '0;
        t.kind = KIND_LINK;
        t.rssi_first = r1;
        t.rssi_second = r2;
        t.link_qual = lq;
        t.signal_to_noise = snr;
        t.transmit_power = txp;
        return t;
    endfunction

    function automatic t_telem telem_batt(logic [15:0] v, logic [15:0] c, logic [15:0] cap);
        t_telem t;
        t = '0;
        t.kind = KIND_BATT;
        t.batt_voltage = v;
        t.batt_current = c;
        t.used_capacity = cap;
        return t;
    endfunction

    function automatic t_row frm(logic [7:0] second, logic [7:0] dir, logic [7:0] len,
                                 logic [7:0] func, logic [0:11][7:0] pay, logic bad_sum,
                                 t_expect_src src, t_telem given);
        t_row r;
        r = '0;
        r.second = second;
        r.dir = dir;
        r.len = len;
        r.func = func;
        r.pay = pay;
        r.bad_sum = bad_sum;
        r.src = src;
        r.given = given;
        return r;
    endfunction

    function automatic t_row codes_row(logic [7:0] link_c, logic [7:0] batt_c);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.link_c = link_c;
        r.batt_c = batt_c;
        return r;
    endfunction

    task automatic parser_restart();
        pr_phase = PH_IDLE;
        pr_to_host = 1'b0;
        pr_len = 8'h00;
        pr_func = 8'h00;
        pr_xor = 8'h00;
        pr_count = 8'h00;
    endtask

    // Advance the parser model by one byte; hit is set when a record is decoded
    task automatic telemetry_for_byte(input logic [7:0] b, output bit hit, output t_telem res);
        hit = 1'b0;
        res = '0;
        case (pr_phase)
            PH_M: begin
                if (b == SYNC_M) pr_phase = PH_DIR;
                else parser_restart();
            end
            PH_DIR: begin
                if (b == DIR_TO_DEV || b == DIR_FROM_DEV) begin
                    pr_to_host = (b == DIR_FROM_DEV);
                    pr_phase = PH_LEN;
                end else begin
                    parser_restart();
                end
            end
            PH_LEN: begin
                pr_len = b;
                pr_xor = b;
                pr_count = 8'h00;
                pr_phase = PH_FUNC;
            end
            PH_FUNC: begin
                pr_func = b;
                pr_xor ^= b;
                pr_phase = (pr_len == 8'h00) ? PH_SUM : PH_PAY;
            end
            PH_PAY: begin
                if (pr_count < HEAD) pr_head[pr_count] = b;
                pr_xor ^= b;
                pr_count++;
                if (pr_count >= pr_len) pr_phase = PH_SUM;
            end
            PH_SUM: begin
                // link code wins when both codes match
                if (pr_xor == b && pr_to_host) begin
                    if (pr_func == link_code) begin
                        if (pr_count >= COMPACT_MIN_LEN) begin
                            hit = 1'b1;
                            res.kind = KIND_LINK;
                            res.rssi_first = pr_head[0];
                            if (pr_count >= LEGACY_MIN_LEN) begin
                                res.rssi_second = pr_head[1];
                                res.link_qual = pr_head[2];
                                res.signal_to_noise = pr_head[3];
                                res.transmit_power = pr_head[4];
                            end else begin
                                res.rssi_second = pr_head[0];
                                res.link_qual = pr_head[1];
                                res.signal_to_noise = pr_head[2];
                                res.transmit_power = pr_head[3];
                            end
                        end
                    end else if (pr_func == batt_code && pr_count >= BATT_MIN_LEN) begin
                        hit = 1'b1;
                        res.kind = KIND_BATT;
                        res.batt_voltage = {pr_head[0], pr_head[1]};
                        res.batt_current = {pr_head[2], pr_head[3]};
                        res.used_capacity = {pr_head[4], pr_head[5]};
                    end
                end
                parser_restart();
            end
            default: begin
                pr_phase = (b == SYNC_DOLLAR) ? PH_M : PH_IDLE;
            end
        endcase
    endtask

    // Send one byte after a random gap, then predict its outcome
    task automatic feed_byte(input logic [7:0] b);
        bit     hit;
        t_telem res;
        int     gap;
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 59) == 0) send_calm = $urandom_range(20, 80);
            gap = idle_len();
        end
        repeat (gap) @(negedge i_clk) i_in_valid <= 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
        telemetry_for_byte(b, hit, res);
        if (hit && !hold_prediction) expect_add(res);
    endtask

    // Full frame; payload past the table's twelve bytes is random
    task automatic send_frame(input logic [7:0] second, input logic [7:0] dir,
                              input logic [7:0] len, input logic [7:0] func,
                              input logic [0:11][7:0] pay, input logic bad_sum);
        logic [7:0] sum;
        logic [7:0] pb;
        sum = len ^ func;
        feed_byte(SYNC_DOLLAR);
        feed_byte(second);
        feed_byte(dir);
        feed_byte(len);
        feed_byte(func);
        for (int i = 0; i < len; i++) begin
            pb = (i < 12) ? pay[i] : 8'($urandom);
            sum ^= pb;
            feed_byte(pb);
        end
        if (bad_sum) sum ^= 8'($urandom_range(1, 255));
        feed_byte(sum);
    endtask

    // Drop valid and wait until every expected record has come out
    task automatic wait_results_done();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (telemetry_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Bring the parser back to idle, drain, then write both function codes
    task automatic set_codes(input logic [7:0] link_c, input logic [7:0] batt_c);
        while (pr_phase != PH_IDLE) feed_byte(8'h00);
        wait_results_done();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_LINK_CODE;
        i_cfg_data <= link_c;
        @(negedge i_clk);
        i_cfg_index <= CFG_BATT_CODE;
        i_cfg_data <= batt_c;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        link_code = link_c;
        batt_code = batt_c;
        code_sets++;
    endtask

    // Mostly well-formed frames with random content, plus broken headers and noise
    task automatic send_random_traffic();
        int               pick;
        int               n;
        logic [7:0]       dir;
        logic [7:0]       len;
        logic [7:0]       func;
        logic [0:11][7:0] pay;
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
            dir = ($urandom_range(0, 9) < 8) ? DIR_FROM_DEV : DIR_TO_DEV;
            n = $urandom_range(0, 99);
            func = (n < 40) ? link_code : (n < 80) ? batt_code : 8'($urandom);
            n = $urandom_range(0, 99);
            len = (n < 90) ? 8'($urandom_range(0, 12)) :
                  (n < 98) ? 8'($urandom_range(13, 40)) : 8'($urandom_range(41, 255));
            for (int i = 0; i < 12; i++) pay[i] = 8'($urandom);
            send_frame(SYNC_M, dir, len, func, pay, $urandom_range(0, 9) == 0);
        end else if (pick < 90) begin
            feed_byte(SYNC_DOLLAR);
            if ($urandom_range(0, 1) == 1) feed_byte(SYNC_M);
            feed_byte(8'($urandom));
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) feed_byte(8'($urandom));
        end
    endtask

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Output side: random stalls with calm stretches
    always @(negedge i_clk) begin
        if (stall_left > 0) stall_left--;
        else if (free_left > 0) free_left--;
        else if ($urandom_range(0, 59) == 0) free_left = $urandom_range(20, 80);
        else stall_left = idle_len();
        i_out_stall <= (stall_left > 0);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_telem want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (telemetry_q.size() == 0) begin
                $error("result transaction with nothing expected (kind %0d)", o_frame_kind);
                err_count++;
            end else begin
                want = telemetry_q.pop_front();
                check_field("frame_kind", want.kind, o_frame_kind);
                check_field("rssi_first", want.rssi_first, o_rssi_first);
                check_field("rssi_second", want.rssi_second, o_rssi_second);
                check_field("link_qual", want.link_qual, o_link_qual);
                check_field("signal_to_noise", want.signal_to_noise, o_signal_to_noise);
                check_field("transmit_power", want.transmit_power, o_transmit_power);
                check_field("batt_voltage", want.batt_voltage, o_batt_voltage);
                check_field("batt_current", want.batt_current, o_batt_current);
                check_field("used_capacity", want.used_capacity, o_used_capacity);
                if (want.kind == KIND_LINK) link_seen++;
                else batt_seen++;
            end
        end
    end

    // Watchdog: cycles without any transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
        else quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles, %0d results outstanding",
                   WATCHDOG_LIMIT, telemetry_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] lc;
        int         stop_at;
        for (int i = 0; i < HEAD; i++) pr_head[i] = 8'h00;

        // Directed frames; codes start at their reset values
        plan_add(frm(SYNC_M, DIR_FROM_DEV, 8'd6, BATT_CODE_RST,
                     96'hFFFF_0000_8001_0000_0000_0000, 1'b0, GIVEN,
                     telem_batt(16'hFFFF, 16'h0000, 16'h8001)));
        plan_add(frm(SYNC_M, DIR_FROM_DEV, 8'd10, LINK_CODE_RST,
                     96'h807F_FF80_00AA_BBCC_DDEE_0000, 1'b0, GIVEN,
                     telem_link(8'h80, 8'h7F, 8'hFF, 8'h80, 8'h00)));
        plan_add(frm(SYNC_M, DIR_FROM_DEV, 8'd4, LINK_CODE_RST,
                     96'h7F00_7FFF_0000_0000_0000_0000, 1'b0, GIVEN,
                     telem_link(8'h7F, 8'h7F, 8'h00, 8'h7F, 8'hFF)));
        // too short for either layout
        plan_add(frm(SYNC_M, DIR_FROM_DEV, 8'd3, LINK_CODE_RST,
                     96'h0102_0300_0000_0000_0000_0000, 1'b0, NO_RESULT, '0));
        plan_add(frm(SYNC_M, DIR_FROM_DEV, 8'd5, BATT_CODE_RST,
                     96'h1122_3344_5500_0000_0000_0000, 1'b0, NO_RESULT, '0));
        // bad checksum
        plan_add(frm(SYNC_M, DIR_FROM_DEV, 8'd6, BATT_CODE_RST,
                     96'h0C80_0123_0045_0000_0000_0000, 1'b1, NO_RESULT, '0));
        // frame toward the device
        plan_add(frm(SYNC_M, DIR_TO_DEV, 8'd4, LINK_CODE_RST,
                     96'h5060_7080_0000_0000_0000_0000, 1'b0, NO_RESULT, '0));
        // unknown function code
        plan_add(frm(SYNC_M, DIR_FROM_DEV, 8'd2, 8'h00,
                     96'hFFFF_0000_0000_0000_0000_0000, 1'b0, NO_RESULT, '0));
        // zero length: checksum right after the function code
        plan_add(frm(SYNC_M, DIR_FROM_DEV, 8'd0, LINK_CODE_RST,
                     '0, 1'b0, NO_RESULT, '0));
        // '$' where 'M' belongs is not a new start; the rest is line noise
        plan_add(frm(SYNC_DOLLAR, DIR_FROM_DEV, 8'd6, BATT_CODE_RST,
                     96'h0102_0304_0506_0000_0000_0000, 1'b0, FROM_MODEL, '0));
        // bad direction byte
        plan_add(frm(SYNC_M, 8'h41, 8'd4, LINK_CODE_RST,
                     96'h1020_3040_0000_0000_0000_0000, 1'b0, FROM_MODEL, '0));
        // payload longer than the stored head
        plan_add(frm(SYNC_M, DIR_FROM_DEV, 8'd12, LINK_CODE_RST,
                     96'hC3D4_E5F6_0708_090A_0B0C_0D0E, 1'b0, FROM_MODEL, '0));
        plan_add(codes_row(8'h00, 8'hFF));
        plan_add(frm(SYNC_M, DIR_FROM_DEV, 8'd9, 8'h00,
                     96'hA1B2_C3D4_E5F6_0718_2900_0000, 1'b0, FROM_MODEL, '0));
        plan_add(frm(SYNC_M, DIR_FROM_DEV, 8'd8, 8'hFF,
                     96'h1234_5678_9ABC_DEF0_0000_0000, 1'b0, FROM_MODEL, '0));
        // equal codes: link decode has priority
        plan_add(codes_row(8'h77, 8'h77));
        plan_add(frm(SYNC_M, DIR_FROM_DEV, 8'd6, 8'h77,
                     96'h9988_7766_5544_0000_0000_0000, 1'b0, FROM_MODEL, '0));
        plan_add(codes_row(8'hFF, 8'h00));
        plan_add(frm(SYNC_M, DIR_FROM_DEV, 8'd6, 8'h00,
                     '0, 1'b0, FROM_MODEL, '0));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                set_codes(plan[i].link_c, plan[i].batt_c);
            end else begin
                hold_prediction = (plan[i].src != FROM_MODEL);
                send_frame(plan[i].second, plan[i].dir, plan[i].len, plan[i].func,
                           plan[i].pay, plan[i].bad_sum);
                hold_prediction = 1'b0;
                if (plan[i].src == GIVEN) expect_add(plan[i].given);
            end
        end

        // Random traffic under several code settings
        for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
            case (ph)
                0: set_codes(LINK_CODE_RST, BATT_CODE_RST);
                1: set_codes(8'h00, 8'hFF);
                2: set_codes(8'hFF, 8'h00);
                3: begin
                    lc = 8'($urandom);
                    set_codes(lc, lc);
                end
                4: set_codes(SYNC_DOLLAR, DIR_FROM_DEV);
                default: set_codes(8'($urandom), 8'($urandom));
            endcase
            stop_at = bytes_sent + RANDOM_BYTES / RANDOM_SETTINGS;
            while (bytes_sent < stop_at) send_random_traffic();
        end

        wait_results_done();
        $display("Sent %0d bytes under %0d function-code settings", bytes_sent, code_sets);
        $display("Checked %0d link and %0d battery results", link_seen, batt_seen);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- msp_telemetry_frame_parser_unit.f -----
hw/rtl/mtfp_pkg.sv
hw/rtl/mtfp_decode.sv
hw/rtl/msp_telemetry_frame_parser_unit.sv
tb/tb.sv
